// ----- rtl/core/grid_walk_coverage_tracker_macros.svh -----
// ---------------------------------------------------------------------------
// Grid walk coverage tracker assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ---------------------------------------------------------------------------
`ifndef GRID_WALK_COVERAGE_TRACKER_MACROS_SVH
`define GRID_WALK_COVERAGE_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GWCT_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gwct check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define GWCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gwct check failed: next-cycle implication");

`endif

// ----- rtl/core/gwct_pkg.sv -----
// ---------------------------------------------------------------------------
// Grid walk coverage tracker package
// Shared widths, command and direction codes, and controller states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gwct_pkg;

    localparam int MAX_HALF_DEF = 64;

    localparam int HALF_W   = 7;
    localparam int COUNT_W  = 15;
    localparam int VCOUNT_W = 14;
    localparam int POS_W    = 8;
    localparam int EPOCH_W  = 4;

    localparam logic [HALF_W-1:0] HALF_SIZE_RST = 7'd64;

    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_STEP    = 1'b1;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } state_t;

endpackage

// ----- rtl/core/gwct_step_unit.sv -----
// ---------------------------------------------------------------------------
// Grid walk step unit
// Moves the walker one cell, tests the boundary and forms the map address.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gwct_step_unit #(
    parameter int MAX_HALF = gwct_pkg::MAX_HALF_DEF,
    parameter int COORD_W  = $clog2(MAX_HALF + 1) + 1,
    parameter int AXIS_W   = $clog2(2 * MAX_HALF)
) (
    input  logic signed [COORD_W-1:0]       x,
    input  logic signed [COORD_W-1:0]       y,
    input  logic [1:0]                      direction,
    input  logic [gwct_pkg::HALF_W-1:0]     half_size,
    output logic signed [COORD_W-1:0]       next_x,
    output logic signed [COORD_W-1:0]       next_y,
    output logic                            at_edge,
    output logic [2*AXIS_W-1:0]             addr
);

    localparam int N_W   = ((COORD_W > gwct_pkg::HALF_W) ? COORD_W : gwct_pkg::HALF_W) + 1;
    localparam int CMP_W = N_W + 1;
    localparam logic signed [COORD_W-1:0] ONE = COORD_W'(1);

    logic [N_W-1:0]          hs_ext;
    logic [N_W-1:0]          max_n;
    logic [N_W-1:0]          n_eff;
    logic signed [CMP_W-1:0] sx;
    logic signed [CMP_W-1:0] sy;
    logic signed [CMP_W-1:0] sn;
    logic [COORD_W:0]        ux;
    logic [COORD_W:0]        uy;

    // clamp the boundary distance to 1..MAX_HALF
    always_comb
    begin
        hs_ext = N_W'(half_size);
        max_n  = N_W'(MAX_HALF);
        if (hs_ext == '0)
            n_eff = N_W'(1);
        else if (hs_ext > max_n)
            n_eff = max_n;
        else
            n_eff = hs_ext;
    end

    always_comb
    begin
        next_x = x;
        next_y = y;
        case (gwct_pkg::dir_t'(direction))
            gwct_pkg::DIR_UP:    next_y = y + ONE;
            gwct_pkg::DIR_RIGHT: next_x = x + ONE;
            gwct_pkg::DIR_DOWN:  next_y = y - ONE;
            gwct_pkg::DIR_LEFT:  next_x = x - ONE;
            default:             next_x = x;
        endcase
    end

    always_comb
    begin
        sx = CMP_W'(next_x);
        sy = CMP_W'(next_y);
        sn = CMP_W'(n_eff);
        at_edge = (sx >= sn) || (sx <= -sn) || (sy >= sn) || (sy <= -sn);
    end

    // offset interior coordinates into 0..2*MAX_HALF-1
    always_comb
    begin
        ux   = (COORD_W + 1)'(next_x) + (COORD_W + 1)'(MAX_HALF);
        uy   = (COORD_W + 1)'(next_y) + (COORD_W + 1)'(MAX_HALF);
        addr = {ux[AXIS_W-1:0], uy[AXIS_W-1:0]};
    end

endmodule

// ----- rtl/core/gwct_visit_mem.sv -----
// ---------------------------------------------------------------------------
// Grid walk visit memory
// One write port, one registered read port; holds an epoch tag per cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gwct_visit_mem #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = gwct_pkg::EPOCH_W
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] visit_mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            visit_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= visit_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/grid_walk_coverage_tracker.sv -----
// ---------------------------------------------------------------------------
// Grid walk coverage tracker
// Follows a walker on a square grid and counts distinct interior cells.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, cmd, direction): cmd restart puts the
//   walker at the origin and starts a fresh map; cmd step, unless finished,
//   moves one cell. Output channel (out_valid/out_ready): one item per input
//   item with the distinct cell count, the finished flag and walker position.
//   cfg_wr_en/cfg_wr_data write half_size, the boundary distance; write it
//   only while no item is in flight.
//   Flow: the accept cycle issues a synchronous read of the visited map;
//   the busy state then checks the tag, writes the map and loads the
//   output register. One item is in work at a time.
//   Each map cell stores an epoch tag; a restart bumps the epoch, so old
//   marks fall out without touching the memory.
//   Reset: the map is swept to zero, all 2**(2*clog2(2*MAX_HALF)) entries
//   (16384 at the default), with in_ready low. The same sweep runs after the
//   restart that wraps the epoch counter (every 15th restart).
//   Stall: a pending result sits in the output register; the current item
//   holds in the map stage until the register frees up, and in_ready stays
//   low meanwhile.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_walk_coverage_tracker #(
    parameter int MAX_HALF = gwct_pkg::MAX_HALF_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 cmd,
    input  logic [1:0]                           direction,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [gwct_pkg::VCOUNT_W-1:0]        visited_count,
    output logic                                 finished,
    output logic signed [gwct_pkg::POS_W-1:0]    x_pos,
    output logic signed [gwct_pkg::POS_W-1:0]    y_pos,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [gwct_pkg::HALF_W-1:0]          cfg_wr_data
);

    localparam int COORD_W = $clog2(MAX_HALF + 1) + 1;
    localparam int AXIS_W  = $clog2(2 * MAX_HALF);
    localparam int ADDR_W  = 2 * AXIS_W;
    localparam int EW      = gwct_pkg::EPOCH_W;
    localparam int CW      = gwct_pkg::COUNT_W;

    // control state
    gwct_pkg::state_t            state_reg, state_next;
    logic [gwct_pkg::HALF_W-1:0] half_size_reg, half_size_next;
    logic                        done_reg, done_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [EW-1:0]               epoch_reg, epoch_next;
    logic                        wrap_reg, wrap_next;
    logic                        lookup_reg, lookup_next;
    logic [ADDR_W-1:0]           clr_cnt_reg, clr_cnt_next;
    logic                        out_valid_reg, out_valid_next;

    // walker position and payload
    logic signed [COORD_W-1:0]   x_reg, x_next;
    logic signed [COORD_W-1:0]   y_reg, y_next;
    logic [ADDR_W-1:0]           addr_reg, addr_next;
    logic [gwct_pkg::VCOUNT_W-1:0] vcount_reg, vcount_next;
    logic                        fin_reg, fin_next;
    logic signed [gwct_pkg::POS_W-1:0] xo_reg, xo_next;
    logic signed [gwct_pkg::POS_W-1:0] yo_reg, yo_next;

    // step unit results
    logic signed [COORD_W-1:0]   step_x;
    logic signed [COORD_W-1:0]   step_y;
    logic                        step_edge;
    logic [ADDR_W-1:0]           step_addr;

    // map port
    logic                        rd_en;
    logic [EW-1:0]               rd_data;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [EW-1:0]               wr_data;

    logic                        accept;
    logic                        slot_free;
    logic                        seen;

    gwct_step_unit #(
        .MAX_HALF (MAX_HALF),
        .COORD_W  (COORD_W),
        .AXIS_W   (AXIS_W)
    ) u_step (
        .x         (x_reg),
        .y         (y_reg),
        .direction (direction),
        .half_size (half_size_reg),
        .next_x    (step_x),
        .next_y    (step_y),
        .at_edge   (step_edge),
        .addr      (step_addr)
    );

    gwct_visit_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (EW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (step_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign in_ready  = (state_reg == gwct_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // The origin is marked by every restart and is never cleared, so treat it
    // as seen without a map entry. Any other cell is seen when its tag matches
    // the current epoch.
    assign seen = (rd_data == epoch_reg) || ((x_reg == '0) && (y_reg == '0));

    always_comb
    begin
        state_next     = state_reg;
        half_size_next = cfg_wr_en ? cfg_wr_data : half_size_reg;
        done_next      = done_reg;
        count_next     = count_reg;
        epoch_next     = epoch_reg;
        wrap_next      = wrap_reg;
        lookup_next    = lookup_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        x_next         = x_reg;
        y_next         = y_reg;
        addr_next      = addr_reg;
        vcount_next    = vcount_reg;
        fin_next       = fin_reg;
        xo_next        = xo_reg;
        yo_next        = yo_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = epoch_reg;

        case (state_reg)
            gwct_pkg::ST_CLEAR:
            begin
                // sweep one entry per cycle back to the null tag
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == {ADDR_W{1'b1}})
                begin
                    epoch_next = EW'(1);
                    wrap_next  = 1'b0;
                    state_next = gwct_pkg::ST_IDLE;
                end
            end

            gwct_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    lookup_next = 1'b0;
                    state_next  = gwct_pkg::ST_BUSY;
                    if (cmd == gwct_pkg::CMD_RESTART)
                    begin
                        x_next     = '0;
                        y_next     = '0;
                        done_next  = 1'b0;
                        count_next = CW'(1);
                        epoch_next = epoch_reg + EW'(1);
                        // tag space exhausted: sweep the map after this item
                        if (epoch_next == '0)
                        begin
                            wrap_next = 1'b1;
                        end
                    end
                    else if (!done_reg)
                    begin
                        x_next = step_x;
                        y_next = step_y;
                        if (step_edge)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            // fetch the tag of the new cell
                            rd_en       = 1'b1;
                            addr_next   = step_addr;
                            lookup_next = 1'b1;
                        end
                    end
                end
            end

            gwct_pkg::ST_BUSY:
            begin
                // hold the item here until the output register frees up
                if (slot_free)
                begin
                    if (lookup_reg && !seen)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    out_valid_next = 1'b1;
                    vcount_next    = count_next[gwct_pkg::VCOUNT_W-1:0];
                    fin_next       = done_reg;
                    xo_next        = gwct_pkg::POS_W'(x_reg);
                    yo_next        = gwct_pkg::POS_W'(y_reg);
                    lookup_next    = 1'b0;
                    state_next     = wrap_reg ? gwct_pkg::ST_CLEAR : gwct_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = gwct_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gwct_pkg::ST_CLEAR;
            half_size_reg <= gwct_pkg::HALF_SIZE_RST;
            done_reg      <= 1'b0;
            count_reg     <= CW'(1);
            epoch_reg     <= EW'(1);
            wrap_reg      <= 1'b0;
            lookup_reg    <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            half_size_reg <= half_size_next;
            done_reg      <= done_next;
            count_reg     <= count_next;
            epoch_reg     <= epoch_next;
            wrap_reg      <= wrap_next;
            lookup_reg    <= lookup_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        vcount_reg <= vcount_next;
        fin_reg    <= fin_next;
        xo_reg     <= xo_next;
        yo_reg     <= yo_next;
    end

    assign out_valid     = out_valid_reg;
    assign visited_count = vcount_reg;
    assign finished      = fin_reg;
    assign x_pos         = xo_reg;
    assign y_pos         = yo_reg;

endmodule

// ----- rtl/core/gwct_checker.sv -----
// ---------------------------------------------------------------------------
// Grid walk coverage tracker port checker
// Watches the top-level ports for handshake and latency slips.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_walk_coverage_tracker_macros.svh"

module gwct_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [gwct_pkg::VCOUNT_W-1:0]        visited_count,
    input logic                                 finished,
    input logic signed [gwct_pkg::POS_W-1:0]    x_pos,
    input logic signed [gwct_pkg::POS_W-1:0]    y_pos
);

    logic                                            out_pending;
    logic                                            in_take;
    logic [gwct_pkg::VCOUNT_W+2*gwct_pkg::POS_W:0]   out_payload;

    assign out_pending = out_valid && !out_ready;
    assign in_take     = in_valid && in_ready && (!out_valid || out_ready);
    assign out_payload = {visited_count, finished, x_pos, y_pos};

    // a stalled result holds its value
    `GWCT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_pending, out_valid && $stable(out_payload))

    // one item in work at a time: no accept right after an accept
    `GWCT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

    // with the output free at the accept, the result passes the busy state into the output register without a stall
    `GWCT_ASSERT_IMPLY(a_latency, clk, rst_n, in_take, ##2 out_valid)

endmodule

bind grid_walk_coverage_tracker gwct_checker u_gwct_checker (.*);
